// ===== hw/rtl/cpfp_pkg.sv =====
// Package for the per-frame command pacer: shared constants, enums and structs.
// No dependencies; every file of the block but cpfp_ram imports it.
`timescale 1ns / 1ps

package cpfp_pkg;

  localparam int unsigned WORD_WIDTH   = 64;
  localparam int unsigned QUEUE_DEPTH  = 64;
  localparam int unsigned BUDGET_W     = 4;
  localparam int unsigned DELAY_W      = 6;
  localparam logic [BUDGET_W-1:0] BUDGET_RESET = 4'd2;
  localparam logic [DELAY_W-1:0]  DELAY_MAX    = 6'd63;

  typedef enum logic {
    REQ_SUBMIT = 1'b0,
    REQ_TICK   = 1'b1
  } req_kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EMIT,
    ST_WAIT
  } pacer_state_e;

  typedef struct packed {
    logic      valid;
    req_kind_e kind;
  } front_status_t;

  typedef struct packed {
    logic               dropped;
    logic               last;
    logic [DELAY_W-1:0] delay;
  } res_ctl_t;

endpackage

// ===== hw/rtl/cpfp_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module cpfp_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 64,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/cpfp_front.sv =====
// Front end of the pacer: accepts request words, classifies them and holds
// them in a two-entry queue for the back end. Depends on cpfp_pkg.
`timescale 1ns / 1ps

module cpfp_front import cpfp_pkg::*; #(
  parameter int unsigned WordWidth = WORD_WIDTH
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  output logic                 full_o,
  input  logic                 req_type_i,
  input  logic [WordWidth-1:0] cmd_word_i,
  input  logic                 take_i,
  output front_status_t        status_o,
  output logic [WordWidth-1:0] word_o
);

  logic [1:0]           cnt_q, cnt_d;
  logic                 head_q, head_d;
  req_kind_e            kind_q [2];
  logic [WordWidth-1:0] word_q [2];
  logic                 tail;
  logic                 push_ok;
  logic                 pop_ok;

  assign full_o  = (cnt_q == 2'd2);
  assign push_ok = push_i && !full_o;
  assign pop_ok  = take_i && (cnt_q != 2'd0);
  assign tail    = head_q ^ cnt_q[0];

  always_comb begin
    cnt_d  = cnt_q;
    head_d = head_q;
    if (pop_ok) begin
      head_d = ~head_q;
    end
    unique case ({push_ok, pop_ok})
      2'b10:   cnt_d = cnt_q + 2'd1;
      2'b01:   cnt_d = cnt_q - 2'd1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= 2'd0;
      head_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      head_q <= head_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      kind_q[tail] <= req_type_i ? REQ_TICK : REQ_SUBMIT;
      word_q[tail] <= cmd_word_i;
    end
  end

  assign status_o.valid = (cnt_q != 2'd0);
  assign status_o.kind  = kind_q[head_q];
  assign word_o         = word_q[head_q];

endmodule

// ===== hw/rtl/cpfp_back.sv =====
// Back end of the pacer: pending word FIFO, frame budget sequencer and a
// two-entry result queue. Depends on cpfp_pkg and cpfp_ram.
`timescale 1ns / 1ps

module cpfp_back import cpfp_pkg::*; #(
  parameter int unsigned WordWidth  = WORD_WIDTH,
  parameter int unsigned QueueDepth = QUEUE_DEPTH
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [BUDGET_W-1:0]  budget_i,
  input  front_status_t        status_i,
  input  logic [WordWidth-1:0] word_i,
  output logic                 take_o,
  input  logic                 pop_i,
  output logic                 empty_o,
  output logic [WordWidth-1:0] sent_word_o,
  output logic                 dropped_o,
  output logic                 last_of_run_o,
  output logic [DELAY_W-1:0]   queue_delay_o
);

  localparam int unsigned AddrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW  = $clog2(QueueDepth + 1);
  localparam int unsigned SumW  = CntW + 1;

  pacer_state_e         state_q, state_d;
  logic [CntW-1:0]      count_q, count_d;
  logic [AddrW-1:0]     rp_q, rp_d;
  logic [BUDGET_W-1:0]  sent_q, sent_d;

  logic [CntW-1:0]      cnt_dec;
  logic [BUDGET_W-1:0]  sent_inc;
  logic [AddrW-1:0]     rp_next;
  logic [SumW-1:0]      wsum;
  logic [AddrW-1:0]     waddr;
  logic                 ram_we;
  logic [WordWidth-1:0] rdata;
  logic                 run_last;

  logic                 o_push, o_pop, o_space;
  logic [WordWidth-1:0] res_word;
  res_ctl_t             res_ctl;
  logic [1:0]           ocnt_q, ocnt_d;
  logic                 ohead_q, ohead_d;
  logic [WordWidth-1:0] oword_q [2];
  res_ctl_t             octl_q  [2];
  logic                 otail;

  // Queue delay is half the pending count, saturated to the field range.
  function automatic logic [DELAY_W-1:0] delay_of(input logic [CntW-1:0] c);
    logic [CntW-1:0] half;
    half = c >> 1;
    if (CntW > DELAY_W && half > CntW'(DELAY_MAX)) begin
      return DELAY_MAX;
    end
    return DELAY_W'(half);
  endfunction

  assign cnt_dec  = count_q - CntW'(1);
  assign sent_inc = sent_q + BUDGET_W'(1);
  assign rp_next  = (rp_q == AddrW'(QueueDepth - 1)) ? '0 : rp_q + AddrW'(1);
  assign wsum     = SumW'(rp_q) + SumW'(count_q);
  assign waddr    = (wsum >= SumW'(QueueDepth)) ? AddrW'(wsum - SumW'(QueueDepth))
                                                : AddrW'(wsum);
  assign run_last = (cnt_dec == '0) || (sent_inc >= budget_i);

  cpfp_ram #(
    .Width(WordWidth),
    .Depth(QueueDepth)
  ) u_pending (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(waddr),
    .wdata_i(word_i),
    .raddr_i(rp_q),
    .rdata_o(rdata)
  );

  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    rp_d     = rp_q;
    sent_d   = sent_q;
    take_o   = 1'b0;
    o_push   = 1'b0;
    ram_we   = 1'b0;
    res_word = word_i;
    res_ctl  = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (status_i.valid && o_space) begin
          take_o = 1'b1;
          unique case (status_i.kind)
            REQ_SUBMIT: begin
              if (count_q == '0 && sent_q < budget_i) begin
                o_push       = 1'b1;
                res_ctl.last = 1'b1;
                sent_d       = sent_inc;
              end else if (count_q == CntW'(QueueDepth)) begin
                o_push          = 1'b1;
                res_ctl.dropped = 1'b1;
                res_ctl.last    = 1'b1;
                res_ctl.delay   = delay_of(count_q);
              end else begin
                ram_we  = 1'b1;
                count_d = count_q + CntW'(1);
              end
            end
            REQ_TICK: begin
              sent_d = '0;
              if (count_q != '0 && budget_i != '0) begin
                state_d = ST_EMIT;
              end
            end
            default: ;
          endcase
        end
      end
      ST_EMIT: begin
        // The word at the read pointer is on the RAM output in this state.
        if (o_space) begin
          o_push        = 1'b1;
          res_word      = rdata;
          res_ctl.last  = run_last;
          res_ctl.delay = delay_of(cnt_dec);
          count_d       = cnt_dec;
          rp_d          = rp_next;
          sent_d        = sent_inc;
          state_d       = run_last ? ST_IDLE : ST_WAIT;
        end
      end
      ST_WAIT: state_d = ST_EMIT;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      rp_q    <= '0;
      sent_q  <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      rp_q    <= rp_d;
      sent_q  <= sent_d;
    end
  end

  // Result queue, two entries.
  assign o_space = (ocnt_q != 2'd2);
  assign o_pop   = pop_i && (ocnt_q != 2'd0);
  assign otail   = ohead_q ^ ocnt_q[0];

  always_comb begin
    ohead_d = o_pop ? ~ohead_q : ohead_q;
    unique case ({o_push, o_pop})
      2'b10:   ocnt_d = ocnt_q + 2'd1;
      2'b01:   ocnt_d = ocnt_q - 2'd1;
      default: ocnt_d = ocnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ocnt_q  <= 2'd0;
      ohead_q <= 1'b0;
    end else begin
      ocnt_q  <= ocnt_d;
      ohead_q <= ohead_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (o_push) begin
      oword_q[otail] <= res_word;
      octl_q[otail]  <= res_ctl;
    end
  end

  assign empty_o       = (ocnt_q == 2'd0);
  assign sent_word_o   = oword_q[ohead_q];
  assign dropped_o     = octl_q[ohead_q].dropped;
  assign last_of_run_o = octl_q[ohead_q].last;
  assign queue_delay_o = octl_q[ohead_q].delay;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(QueueDepth))
    else $error("pending count beyond queue depth");

  a_emit_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT || state_q == ST_WAIT) |-> count_q != '0)
    else $error("drain running with no pending word");

  a_drop_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (o_push && res_ctl.dropped) |-> count_q == CntW'(QueueDepth))
    else $error("word dropped while the queue had room");

  a_tick_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take_o && status_i.kind == REQ_TICK) |=> sent_q == '0)
    else $error("frame tick did not clear the sent count");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    o_push |-> ocnt_q != 2'd2)
    else $error("result written into a full result queue");

endmodule

// ===== hw/rtl/per_frame_command_pacer.sv =====
// Per-frame command pacer: a submitted word that goes straight out is held in
// the front-end queue and then the result queue; a frame tick drains queued
// words in order via the registered RAM read, with a wait state between words.
// Submits are taken one per cycle while the back end is idle and the result
// queue has room. Reset is asynchronous and active low; it empties all queues,
// clears the sent count and loads the frame budget with two.
`timescale 1ns / 1ps

// The front end buffers and classifies incoming words (submit or frame tick).
// The back end owns the bounded pending FIFO, which lives in a RAM with a
// registered read port, and a small sequencer that either sends a submit at
// once, drops it when the FIFO is full, queues it, or, on a tick, drains up to
// the frame budget in order. Results go through a two-entry result queue so
// the sequencer can keep working while the consumer stalls. The pending RAM
// has no reset; entries are only read after they have been written.
module per_frame_command_pacer import cpfp_pkg::*; #(
  parameter int unsigned WordWidth  = WORD_WIDTH,
  parameter int unsigned QueueDepth = QUEUE_DEPTH
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Configuration: frame budget register.
  input  logic                 cfg_we_i,
  input  logic [BUDGET_W-1:0]  cfg_wdata_i,
  // Request side.
  input  logic                 push,
  output logic                 full,
  input  logic                 req_type_i,
  input  logic [WordWidth-1:0] cmd_word_i,
  // Result side.
  output logic                 empty,
  input  logic                 pop,
  output logic [WordWidth-1:0] sent_word_o,
  output logic                 dropped_o,
  output logic                 last_of_run_o,
  output logic [DELAY_W-1:0]   queue_delay_o
);

  logic [BUDGET_W-1:0]  budget_q;
  front_status_t        front_status;
  logic [WordWidth-1:0] front_word;
  logic                 take;

  // The user must change the budget only while the block is idle; the block does
  // not enforce this, and the back end reads the register directly.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      budget_q <= BUDGET_RESET;
    end else if (cfg_we_i) begin
      budget_q <= cfg_wdata_i;
    end
  end

  cpfp_front #(
    .WordWidth(WordWidth)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .full_o    (full),
    .req_type_i(req_type_i),
    .cmd_word_i(cmd_word_i),
    .take_i    (take),
    .status_o  (front_status),
    .word_o    (front_word)
  );

  cpfp_back #(
    .WordWidth (WordWidth),
    .QueueDepth(QueueDepth)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .budget_i     (budget_q),
    .status_i     (front_status),
    .word_i       (front_word),
    .take_o       (take),
    .pop_i        (pop),
    .empty_o      (empty),
    .sent_word_o  (sent_word_o),
    .dropped_o    (dropped_o),
    .last_of_run_o(last_of_run_o),
    .queue_delay_o(queue_delay_o)
  );

endmodule
